@@ design/dcpid_pkg.sv @@
package dcpid_pkg;

  // Fixed field widths of the sample, gain and drive words.
  localparam int SAMPLE_BITS = 16;
  localparam int GAIN_W      = 16;
  localparam int DRIVE_W     = 16;
  localparam int SUM_W       = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KP_A        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_H_A      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_OVER_H_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KP_B        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KI_H_B      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KD_OVER_H_B = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX     = 3'd7;

  // Reset values of the clamp bounds.
  localparam logic signed [CFG_W-1:0] OUT_MIN_RESET = 16'sh8000;
  localparam logic signed [CFG_W-1:0] OUT_MAX_RESET = 16'sh7fff;

  // One input beat: setpoint and measurement for each channel.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] ref_a;
    logic signed [SAMPLE_BITS-1:0] meas_a;
    logic signed [SAMPLE_BITS-1:0] ref_b;
    logic signed [SAMPLE_BITS-1:0] meas_b;
  } in_item_t;

  // One output beat: the drive of each channel.
  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_a;
    logic signed [DRIVE_W-1:0] drive_b;
  } out_item_t;

  // Stage load enables shared by both lanes.
  typedef struct packed {
    logic accept;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

@@ design/dual_channel_pid_controller_core.sv @@
// An accepted input beat is registered in the integrator stage, then in the gain products,
// the sum and clamp, and the rounded drive, where its result beat is presented.
// Throughput: one beat per cycle while the output is not stalled; each lane runs
// its integrator update, then the gain multipliers, the sum and clamp, and rounding.
// Reset (synchronous, active high) clears both integrators and previous errors,
// zeroes the gains, sets the clamp bounds to the full 16-bit range and empties the pipeline.
module dual_channel_pid_controller_core
  import dcpid_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  // Gain and bound registers.
  logic signed [GAIN_W-1:0] kp_a;
  logic signed [GAIN_W-1:0] ki_h_a;
  logic signed [GAIN_W-1:0] kd_over_h_a;
  logic signed [GAIN_W-1:0] kp_b;
  logic signed [GAIN_W-1:0] ki_h_b;
  logic signed [GAIN_W-1:0] kd_over_h_b;
  logic signed [CFG_W-1:0]  out_min;
  logic signed [CFG_W-1:0]  out_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_a        <= '0;
      ki_h_a      <= '0;
      kd_over_h_a <= '0;
      kp_b        <= '0;
      ki_h_b      <= '0;
      kd_over_h_b <= '0;
      out_min     <= OUT_MIN_RESET;
      out_max     <= OUT_MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KP_A:        kp_a        <= cfg_data;
        REG_KI_H_A:      ki_h_a      <= cfg_data;
        REG_KD_OVER_H_A: kd_over_h_a <= cfg_data;
        REG_KP_B:        kp_b        <= cfg_data;
        REG_KI_H_B:      ki_h_b      <= cfg_data;
        REG_KD_OVER_H_B: kd_over_h_b <= cfg_data;
        REG_OUT_MIN:     out_min     <= cfg_data;
        REG_OUT_MAX:     out_max     <= cfg_data;
        default: ;
      endcase
    end
  end

  stage_en_t                 en;
  logic signed [DRIVE_W-1:0] drive_a;
  logic signed [DRIVE_W-1:0] drive_b;

  // Channel A lane.
  dcpid_lane #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_lane_a (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .ref_s     (in_data.ref_a),
    .meas_s    (in_data.meas_a),
    .kp        (kp_a),
    .ki_h      (ki_h_a),
    .kd_over_h (kd_over_h_a),
    .out_min   (out_min),
    .out_max   (out_max),
    .drive     (drive_a)
  );

  // Channel B lane.
  dcpid_lane #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_lane_b (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .ref_s     (in_data.ref_b),
    .meas_s    (in_data.meas_b),
    .kp        (kp_b),
    .ki_h      (ki_h_b),
    .kd_over_h (kd_over_h_b),
    .out_min   (out_min),
    .out_max   (out_max),
    .drive     (drive_b)
  );

  // Stage control and output beat.
  dcpid_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .drive_a   (drive_a),
    .drive_b   (drive_b),
    .en        (en),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ design/dcpid_lane.sv @@
module dcpid_lane
  import dcpid_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  stage_en_t                 en,
  input  logic signed [SAMPLE_BITS-1:0] ref_s,
  input  logic signed [SAMPLE_BITS-1:0] meas_s,
  input  logic signed [GAIN_W-1:0]  kp,
  input  logic signed [GAIN_W-1:0]  ki_h,
  input  logic signed [GAIN_W-1:0]  kd_over_h,
  input  logic signed [CFG_W-1:0]   out_min,
  input  logic signed [CFG_W-1:0]   out_max,
  output logic signed [DRIVE_W-1:0] drive
);

  localparam int ERR_W  = SAMPLE_BITS + 1;
  localparam int DIFF_W = SAMPLE_BITS + 2;
  localparam int PP_W   = GAIN_W + ERR_W;
  localparam int PI_W   = GAIN_W + SUM_W;
  localparam int PD_W   = GAIN_W + DIFF_W;
  localparam int V_W    = PI_W + 2;
  localparam int CL_W   = CFG_W + GAIN_FRAC_BITS;

  // Integrator and previous error; after an accept they hold this beat's sum and error.
  logic signed [SUM_W-1:0]  err_sum;
  logic signed [ERR_W-1:0]  prev_err;
  logic signed [DIFF_W-1:0] diff;

  logic signed [ERR_W-1:0]  err;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  err_sum_next;
  logic signed [DIFF_W-1:0] diff_next;

  // Error, saturating integrator and difference.
  always_comb begin
    err      = ERR_W'(ref_s) - ERR_W'(meas_s);
    sum_wide = (SUM_W+1)'(err_sum) + (SUM_W+1)'(err);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      err_sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      err_sum_next = sum_wide[SUM_W-1:0];
    end
    diff_next = DIFF_W'(err) - DIFF_W'(prev_err);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_sum  <= '0;
      prev_err <= '0;
    end else if (en.accept) begin
      err_sum  <= err_sum_next;
      prev_err <= err;
    end
    if (en.accept) begin
      diff <= diff_next;
    end
  end

  // Three gain products, one multiplier each.
  logic signed [PP_W-1:0] prod_p;
  logic signed [PI_W-1:0] prod_i;
  logic signed [PD_W-1:0] prod_d;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod_p <= kp * prev_err;
      prod_i <= ki_h * err_sum;
      prod_d <= kd_over_h * diff;
    end
  end

  // Sum of products and clamp; the lower bound goes first.
  logic signed [V_W-1:0]  v_sum;
  logic signed [V_W-1:0]  lo;
  logic signed [V_W-1:0]  hi;
  logic signed [V_W-1:0]  v_lo;
  logic signed [V_W-1:0]  v_cl;
  logic signed [CL_W-1:0] clamped;

  always_comb begin
    v_sum = V_W'(prod_p) + V_W'(prod_i) + V_W'(prod_d);
    lo    = V_W'(out_min) <<< GAIN_FRAC_BITS;
    hi    = V_W'(out_max) <<< GAIN_FRAC_BITS;
    v_lo  = (v_sum < lo) ? lo : v_sum;
    v_cl  = (v_lo > hi) ? hi : v_lo;
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      clamped <= v_cl[CL_W-1:0];
    end
  end

  // Round half away from zero into the integer drive.
  generate
    if (GAIN_FRAC_BITS == 0) begin : g_no_round
      always_ff @(posedge clk) begin
        if (en.s4) begin
          drive <= clamped[DRIVE_W-1:0];
        end
      end
    end else begin : g_round
      localparam int RW = CL_W + 1;
      logic signed [RW-1:0] bias;
      logic signed [RW-1:0] rounded;

      always_comb begin
        bias    = clamped[CL_W-1] ? RW'((1 << (GAIN_FRAC_BITS - 1)) - 1)
                                  : RW'(1 << (GAIN_FRAC_BITS - 1));
        rounded = RW'(clamped) + bias;
      end

      always_ff @(posedge clk) begin
        if (en.s4) begin
          drive <= rounded[GAIN_FRAC_BITS +: DRIVE_W];
        end
      end
    end
  endgenerate

  // The channel state moves only on an accepted beat.
  a_sum_holds: assert property (@(posedge clk) disable iff (rst)
    !en.accept |=> $stable(err_sum) && $stable(prev_err))
    else $error("integrator state changed without an accepted beat");

  // A non-negative sum plus a non-negative error never wraps negative.
  a_sat_pos: assert property (@(posedge clk) disable iff (rst)
    en.accept && !err_sum[SUM_W-1] && !err[ERR_W-1] |=> !err_sum[SUM_W-1])
    else $error("integrator wrapped on positive overflow");

  // A negative sum plus a negative error never wraps positive.
  a_sat_neg: assert property (@(posedge clk) disable iff (rst)
    en.accept && err_sum[SUM_W-1] && err[ERR_W-1] |=> err_sum[SUM_W-1])
    else $error("integrator wrapped on negative overflow");

endmodule

@@ design/dcpid_merge.sv @@
module dcpid_merge
  import dcpid_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [DRIVE_W-1:0] drive_a,
  input  logic signed [DRIVE_W-1:0] drive_b,
  output stage_en_t                 en,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_item_t                 out_data
);

  // Occupancy of the lane stages; the last one is the output register.
  logic v1;
  logic v2;
  logic v3;
  logic v4;
  logic ready1;
  logic ready2;
  logic ready3;
  logic ready4;

  // A stage loads when it is empty or its beat moves on.
  always_comb begin
    ready4    = !v4 || !out_stall;
    ready3    = !v3 || ready4;
    ready2    = !v2 || ready3;
    ready1    = !v1 || ready2;
    in_stall  = !ready1;
    en.accept = in_valid && ready1;
    en.s2     = ready2;
    en.s3     = ready3;
    en.s4     = ready4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
      if (ready4) v4 <= v3;
    end
  end

  // Both lanes finish together; their drives form one output beat.
  assign out_valid        = v4;
  assign out_data.drive_a = drive_a;
  assign out_data.drive_b = drive_b;

  // An accepted beat always occupies the first stage next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    en.accept |=> v1)
    else $error("accepted beat lost at the first stage");

  // The block never stalls input while the first stage is free.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> !in_stall)
    else $error("input stalled with an empty first stage");

  // A taken output with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    v4 && !out_stall && !v3 |=> !v4)
    else $error("output beat repeated");

  // A stalled output beat is never overwritten.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    v4 && out_stall |=> v4 && $stable(drive_a) && $stable(drive_b))
    else $error("stalled output beat overwritten");

endmodule
